>>> hw/rtl/s2l_pkg.sv
package s2l_pkg;

    // One Gregorian date
    typedef struct packed {
        logic [11:0] solar_year;
        logic [3:0]  solar_month;
        logic [4:0]  solar_day;
    } t_in;

    // One lunisolar date
    typedef struct packed {
        logic [11:0] moon_year;
        logic [3:0]  moon_month;
        logic [4:0]  lunar_day;
        logic        moon_leap;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_YEAR,
        S_MONTH,
        S_DAY,
        S_LYEAR,
        S_LMONTH,
        S_LLEAP,
        S_FINISH
    } t_state;

    localparam logic [11:0] BASE_YEAR  = 12'd1900;
    localparam logic [11:0] FIRST_YEAR = 12'd2024;
    localparam logic [11:0] LAST_YEAR  = 12'd2100;
    localparam int          TABLE_YEARS = 201;
    localparam logic [7:0]  LAST_IDX   = 8'(TABLE_YEARS - 1);
    localparam logic [3:0]  MONTH_LIM  = 4'd13;
    localparam logic [3:0]  LAST_MONTH = 4'd12;

    // One word per lunar year from 1900: bits 15..4 big months,
    // bits 3..0 leap month number, bit 16 big leap month
    localparam logic [16:0] YEAR_ROM [0:TABLE_YEARS-1] = '{
        17'h04bd8,17'h04ae0,17'h0a570,17'h054d5,17'h0d260,
        17'h0d950,17'h16554,17'h056a0,17'h09ad0,17'h055d2,
        17'h04ae0,17'h0a5b6,17'h0a4d0,17'h0d250,17'h1d255,
        17'h0b540,17'h0d6a0,17'h0ada2,17'h095b0,17'h14977,
        17'h04970,17'h0a4b0,17'h0b4b5,17'h06a50,17'h06d40,
        17'h1ab54,17'h02b60,17'h09570,17'h052f2,17'h04970,
        17'h06566,17'h0d4a0,17'h0ea50,17'h06e95,17'h05ad0,
        17'h02b60,17'h186e3,17'h092e0,17'h1c8d7,17'h0c950,
        17'h0d4a0,17'h1d8a6,17'h0b550,17'h056a0,17'h1a5b4,
        17'h025d0,17'h092d0,17'h0d2b2,17'h0a950,17'h0b557,
        17'h06ca0,17'h0b550,17'h15355,17'h04da0,17'h0a5b0,
        17'h14573,17'h052b0,17'h0a9a8,17'h0e950,17'h06aa0,
        17'h0aea6,17'h0ab50,17'h04b60,17'h0aae4,17'h0a570,
        17'h05260,17'h0f263,17'h0d950,17'h05b57,17'h056a0,
        17'h096d0,17'h04dd5,17'h04ad0,17'h0a4d0,17'h0d4d4,
        17'h0d250,17'h0d558,17'h0b540,17'h0b6a0,17'h195a6,
        17'h095b0,17'h049b0,17'h0a974,17'h0a4b0,17'h0b27a,
        17'h06a50,17'h06d40,17'h0af46,17'h0ab60,17'h09570,
        17'h04af5,17'h04970,17'h064b0,17'h074a3,17'h0ea50,
        17'h06b58,17'h055c0,17'h0ab60,17'h096d5,17'h092e0,
        17'h0c960,17'h0d954,17'h0d4a0,17'h0da50,17'h07552,
        17'h056a0,17'h0abb7,17'h025d0,17'h092d0,17'h0cab5,
        17'h0a950,17'h0b4a0,17'h0baa4,17'h0ad50,17'h055d9,
        17'h04ba0,17'h0a5b0,17'h15176,17'h052b0,17'h0a930,
        17'h07954,17'h06aa0,17'h0ad50,17'h05b52,17'h04b60,
        17'h0a6e6,17'h0a4e0,17'h0d260,17'h0ea65,17'h0d530,
        17'h05aa0,17'h076a3,17'h096d0,17'h04afb,17'h04ad0,
        17'h0a4d0,17'h1d0b6,17'h0d250,17'h0d520,17'h0dd45,
        17'h0b5a0,17'h056d0,17'h055b2,17'h049b0,17'h0a577,
        17'h0a4b0,17'h0aa50,17'h1b255,17'h06d20,17'h0ada0,
        17'h14b63,17'h09370,17'h049f8,17'h04970,17'h064b0,
        17'h168a6,17'h0ea50,17'h06b20,17'h1a6c4,17'h0aae0,
        17'h0a2e0,17'h0d2e3,17'h0c960,17'h0d557,17'h0d4a0,
        17'h0da50,17'h05d55,17'h056a0,17'h0a6d0,17'h055d4,
        17'h052d0,17'h0a9b8,17'h0a950,17'h0b4a0,17'h0b6a6,
        17'h0ad50,17'h055a0,17'h0aba4,17'h0a5b0,17'h052b0,
        17'h0b273,17'h06930,17'h07337,17'h06aa0,17'h0ad50,
        17'h14b55,17'h04b60,17'h0a570,17'h054e4,17'h0d160,
        17'h0e968,17'h0d520,17'h0daa0,17'h16aa6,17'h056d0,
        17'h04ae0,17'h0a9d4,17'h0a2d0,17'h0d150,17'h0f252,
        17'h0d520
    };

    // Gregorian leap year, valid for years 1900..2100
    function automatic logic greg_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != BASE_YEAR) && (y != LAST_YEAR);
    endfunction

    // Days of a common-year Gregorian month, 1 = January
    function automatic logic [4:0] greg_month_days(input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd2:                      d = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // Days of lunar month m (1..12) in a table word
    function automatic logic [8:0] lunar_month_days(input logic [16:0] w,
                                                    input logic [3:0]  m);
        logic [4:0] bit_idx;
        bit_idx = 5'd16 - {1'b0, m};
        return w[bit_idx] ? 9'd30 : 9'd29;
    endfunction

    // Days of the leap month in a table word
    function automatic logic [8:0] lunar_leap_days(input logic [16:0] w);
        return w[16] ? 9'd30 : 9'd29;
    endfunction

    // Days of a whole lunar year: 12 x 29 plus big months plus leap month
    function automatic logic [8:0] lunar_year_days(input logic [16:0] w);
        logic [8:0] total;
        total = 9'd348;
        for (int k = 4; k <= 15; k++) begin
            total = total + {8'd0, w[k]};
        end
        if (w[3:0] != 4'd0) begin
            total = total + lunar_leap_days(w);
        end
        return total;
    endfunction

endpackage

>>> hw/rtl/solar_to_lunar_date_top.sv
// Gregorian to lunisolar date converter. Give it a Gregorian date in
// 2024..2100 and it answers with one lunar year, month, day and leap-month
// flag; any other year answers 1/1/1900, not leap. One item is worked at a
// time and the input stalls meanwhile. A single add/compare unit is stepped
// by the sequencer: it sums Gregorian years from 1900, then the whole months
// of the target year, then the day, then walks lunar years and then lunar
// months and the leap month; accept and hand-off are states of their own.
// An out-of-range year goes straight from accept to hand-off. The hand-off
// waits while an earlier result is still stalled at the output. The finished
// result sits in an output register, so the next item can be accepted while
// it waits.
module solar_to_lunar_date_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  s2l_pkg::t_in    i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output s2l_pkg::t_out   o_out
);

    s2l_pkg::t_state r_state, n_state;
    s2l_pkg::t_in    r_in, n_in;
    logic [11:0]     r_cnt, n_cnt;
    logic [3:0]      r_month, n_month;
    logic [16:0]     r_off, n_off;
    logic [7:0]      r_idx, n_idx;
    logic [16:0]     r_word, n_word;
    logic            r_leap, n_leap;
    logic            r_out_valid, n_out_valid;
    s2l_pkg::t_out   r_out, n_out;

    // Shared adder / comparator
    logic [16:0] add_b;
    logic        add_sub;
    logic [17:0] add_res;
    logic        add_borrow;

    logic [3:0]  mo_lim;
    logic [16:0] rom_word;
    logic [8:0]  dm;
    logic [8:0]  ld;

    assign add_res    = {1'b0, r_off} + {1'b0, (add_sub ? ~add_b : add_b)}
                      + {17'd0, add_sub};
    assign add_borrow = add_sub & ~add_res[17];

    assign mo_lim   = (r_in.solar_month > s2l_pkg::MONTH_LIM) ? s2l_pkg::MONTH_LIM
                                                               : r_in.solar_month;
    assign rom_word = s2l_pkg::YEAR_ROM[r_idx];
    assign dm       = s2l_pkg::lunar_month_days(r_word, r_month);
    assign ld       = s2l_pkg::lunar_leap_days(r_word);

    // Hold state and data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= s2l_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_in    <= n_in;
        r_cnt   <= n_cnt;
        r_month <= n_month;
        r_off   <= n_off;
        r_idx   <= n_idx;
        r_word  <= n_word;
        r_leap  <= n_leap;
        r_out   <= n_out;
    end

    // Sequencer: next state and adder operands
    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_cnt       = r_cnt;
        n_month     = r_month;
        n_off       = r_off;
        n_idx       = r_idx;
        n_word      = r_word;
        n_leap      = r_leap;
        n_out       = r_out;
        n_out_valid = r_out_valid & i_out_stall;
        add_b       = 17'd0;
        add_sub     = 1'b0;

        unique case (r_state)
            s2l_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in;
                    n_cnt   = s2l_pkg::BASE_YEAR;
                    n_month = 4'd1;
                    n_off   = 17'd0;
                    n_idx   = 8'd0;
                    n_leap  = 1'b0;
                    if (i_in.solar_year < s2l_pkg::FIRST_YEAR ||
                        i_in.solar_year > s2l_pkg::LAST_YEAR) begin
                        n_state = s2l_pkg::S_FINISH;
                    end else begin
                        n_state = s2l_pkg::S_YEAR;
                    end
                end
            end

            // Add whole Gregorian years from 1900
            s2l_pkg::S_YEAR: begin
                add_b = s2l_pkg::greg_leap(r_cnt) ? 17'd366 : 17'd365;
                if (r_cnt == r_in.solar_year) begin
                    n_state = s2l_pkg::S_MONTH;
                end else begin
                    n_off = add_res[16:0];
                    n_cnt = r_cnt + 12'd1;
                end
            end

            // Add whole months of the target year
            s2l_pkg::S_MONTH: begin
                add_b = {12'd0, s2l_pkg::greg_month_days(r_month)}
                      + {16'd0, (r_month == 4'd2) && s2l_pkg::greg_leap(r_in.solar_year)};
                if (r_month >= mo_lim) begin
                    n_state = s2l_pkg::S_DAY;
                end else begin
                    n_off   = add_res[16:0];
                    n_month = r_month + 4'd1;
                end
            end

            // Add day - 1 and rebase to 31 January 1900: off - (31 - day)
            s2l_pkg::S_DAY: begin
                add_sub = 1'b1;
                add_b   = {12'd0, ~r_in.solar_day};
                n_off   = add_res[16:0];
                n_idx   = 8'd0;
                n_state = s2l_pkg::S_LYEAR;
            end

            // Drop whole lunar years
            s2l_pkg::S_LYEAR: begin
                add_sub = 1'b1;
                add_b   = {8'd0, s2l_pkg::lunar_year_days(rom_word)};
                if (add_borrow || r_idx == s2l_pkg::LAST_IDX) begin
                    n_word  = rom_word;
                    n_month = 4'd1;
                    n_state = s2l_pkg::S_LMONTH;
                end else begin
                    n_off = add_res[16:0];
                    n_idx = r_idx + 8'd1;
                end
            end

            // Drop lunar months; saturate at the last month of the year
            s2l_pkg::S_LMONTH: begin
                add_sub = 1'b1;
                add_b   = {8'd0, dm};
                if (add_borrow) begin
                    n_state = s2l_pkg::S_FINISH;
                end else if (r_month == s2l_pkg::LAST_MONTH &&
                             r_word[3:0] != s2l_pkg::LAST_MONTH) begin
                    n_off   = {8'd0, dm - 9'd1};
                    n_state = s2l_pkg::S_FINISH;
                end else begin
                    n_off = add_res[16:0];
                    if (r_word[3:0] == r_month) begin
                        n_state = s2l_pkg::S_LLEAP;
                    end else begin
                        n_month = r_month + 4'd1;
                    end
                end
            end

            // Drop the leap month that follows its base month
            s2l_pkg::S_LLEAP: begin
                add_sub = 1'b1;
                add_b   = {8'd0, ld};
                if (add_borrow) begin
                    n_leap  = 1'b1;
                    n_state = s2l_pkg::S_FINISH;
                end else if (r_month == s2l_pkg::LAST_MONTH) begin
                    n_off   = {8'd0, ld - 9'd1};
                    n_leap  = 1'b1;
                    n_state = s2l_pkg::S_FINISH;
                end else begin
                    n_off   = add_res[16:0];
                    n_month = r_month + 4'd1;
                    n_state = s2l_pkg::S_LMONTH;
                end
            end

            // Load the output register once it is free
            s2l_pkg::S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.moon_year  = s2l_pkg::BASE_YEAR + {4'd0, r_idx};
                    n_out.moon_month = r_month;
                    n_out.lunar_day  = r_off[4:0] + 5'd1;
                    n_out.moon_leap  = r_leap;
                    n_out_valid      = 1'b1;
                    n_state          = s2l_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = s2l_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != s2l_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> hw/rtl/s2l_checker.sv
module s2l_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input s2l_pkg::t_in    i_in,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input s2l_pkg::t_out   o_out
);

    // A waiting result holds until taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // An accepted item keeps the block busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // A new result only appears at the end of a conversion
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a conversion");

    // Results stay inside the lunar calendar range
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.moon_month >= 4'd1 && o_out.moon_month <= 4'd12
                     && o_out.lunar_day >= 5'd1 && o_out.lunar_day <= 5'd30
                     && o_out.moon_year >= 12'd1900 && o_out.moon_year <= 12'd2100)
        else $error("result out of range");

endmodule

bind solar_to_lunar_date_top s2l_checker u_s2l_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
